// File: hw/rtl/euler_to_quaternion_unit_assert.svh
// assertion macros for the euler to quaternion unit
`ifndef EULER_TO_QUATERNION_UNIT_ASSERT_SVH
`define EULER_TO_QUATERNION_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on the unit clock
`define ETQ_ASSERT_IMPLY(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on the unit clock
`define ETQ_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`else

`define ETQ_ASSERT_IMPLY(lbl, pre, post, msg)
`define ETQ_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

// File: hw/rtl/etq_pkg.sv
`timescale 1ns / 1ps

package etq_pkg;

   // word widths
   localparam int ANGLE_WIDTH = 16;
   localparam int QUAT_WIDTH  = 16;

   // cordic datapath
   localparam int CORDIC_STEPS = 16;
   localparam int TH_W         = 20;
   localparam int TRIG_W       = 20;

   localparam logic signed [TH_W-1:0] CORDIC_GAIN = 20'sd39797;
   localparam logic signed [TH_W-1:0] HALF_PI_Q16 = 20'sd102944;
   localparam logic signed [TH_W-1:0] PI_Q16      = 20'sd205887;

   localparam logic signed [TH_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
      20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150,
      20'sd4091,  20'sd2047,  20'sd1024,  20'sd512,
      20'sd256,   20'sd128,   20'sd64,    20'sd32,
      20'sd16,    20'sd8,     20'sd4,     20'sd2
   };

   // magnitude below 0.0001 in q24 skips the normalize
   localparam int MAG_MIN_Q24 = 1678;

   // half angle in q16: angle is q3.(w-3), so shift by 18 - w
   localparam int HA_SHR = (ANGLE_WIDTH >= 18) ? ANGLE_WIDTH - 18 : 0;
   localparam int HA_SHL = (ANGLE_WIDTH < 18) ? 18 - ANGLE_WIDTH : 0;
   localparam int HA_W   = ANGLE_WIDTH + HA_SHL;

   typedef struct packed {
      logic signed [ANGLE_WIDTH-1:0] angle_z;
      logic signed [ANGLE_WIDTH-1:0] angle_x;
      logic signed [ANGLE_WIDTH-1:0] angle_y;
   } etq_req_type;

   typedef struct packed {
      logic signed [QUAT_WIDTH-1:0] quat_w;
      logic signed [QUAT_WIDTH-1:0] quat_x;
      logic signed [QUAT_WIDTH-1:0] quat_y;
      logic signed [QUAT_WIDTH-1:0] quat_z;
   } etq_rsp_type;

   // half of an input angle in q16 radians, floor rounding
   function automatic logic signed [TH_W-1:0] half_angle(input logic signed [ANGLE_WIDTH-1:0] a);
      logic signed [HA_W-1:0] wide;
      wide = HA_W'(a);
      wide = (wide >>> HA_SHR) <<< HA_SHL;
      return TH_W'(wide);
   endfunction

endpackage

// File: hw/rtl/euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
// euler angles (z, x, y rotations, signed q3.13 radians) to a unit quaternion
// (w, x, y, z, signed q1.14, saturated to +/-1).
// req channel: req_valid / req_stall / req_data carries one angle word; a word
//   is taken at a clock edge with req_valid high and req_stall low.
// rsp channel: rsp_valid / rsp_stall / rsp_data returns one quaternion word
//   per angle word, in order.
// the pipeline has 17 cordic stages (the first loaded at acceptance), 6 product
//   and sum stages, 29 square root stages (the sum, then one root bit each),
//   QUAT_WIDTH division stages (operand load, then one quotient bit each) and
//   the output register.
// throughput: one word per cycle while req_stall is low; every stage is a
//   register slice and all three cordic rotators, sixteen multipliers and four
//   dividers run in parallel.
// reset: synchronous, clears every valid bit, the output valid and the skid
//   flag; no word is in flight afterward.
// stall: the output register holds while rsp_stall is high; one further word
//   lands in a skid slot, and while that slot is full req_stall is high and the
//   whole pipeline freezes. nothing is dropped or repeated.
module euler_to_quaternion_unit
   import etq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  etq_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output etq_rsp_type rsp_data
);

`include "euler_to_quaternion_unit_assert.svh"

   localparam int PAIR_W      = 2 * TRIG_W;
   localparam int TRI_W       = PAIR_W + TRIG_W;
   localparam int PROD_SHIFT  = 24;
   localparam int Q_W         = 28;
   localparam int SUM_W       = 2 * Q_W;
   localparam int SQRT_STEPS  = Q_W;
   localparam int FRAC_Q      = QUAT_WIDTH - 2;
   localparam int QT_W        = FRAC_Q + 1;
   localparam int R_W         = Q_W + 1;
   localparam int SH_DN       = (FRAC_Q <= PROD_SHIFT) ? PROD_SHIFT - FRAC_Q : 0;
   localparam int SH_UP       = (FRAC_Q > PROD_SHIFT) ? FRAC_Q - PROD_SHIFT : 0;
   localparam int FIN_W       = Q_W + QT_W + 1;

   localparam logic signed [FIN_W-1:0] ONE_F     = FIN_W'(longint'(1) <<< FRAC_Q);
   localparam logic signed [FIN_W-1:0] NEG_ONE_F = -ONE_F;

   // valid bit index of each stage
   localparam int V_TRIG     = CORDIC_STEPS + 1;
   localparam int V_PAIR     = V_TRIG + 1;
   localparam int V_TRI      = V_PAIR + 1;
   localparam int V_COMP     = V_TRI + 1;
   localparam int V_SQ       = V_COMP + 1;
   localparam int V_ADD1     = V_SQ + 1;
   localparam int V_SQRT0    = V_ADD1 + 1;
   localparam int V_SQRT_END = V_SQRT0 + SQRT_STEPS;
   localparam int V_DIV0     = V_SQRT_END + 1;
   localparam int V_LAST     = V_DIV0 + QT_W;
   localparam int N_VLD      = V_LAST + 1;

   // flow control
   logic             en;
   logic [N_VLD-1:0] vld_ff;
   logic             skid_full_ff;
   logic             rsp_valid_ff;
   etq_rsp_type      skid_ff;
   etq_rsp_type      rsp_data_ff;
   etq_rsp_type      fin_data;
   logic             take;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign take      = rsp_valid_ff && !rsp_stall;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[N_VLD-2:0], req_valid};
      end
   end

   // angle index: 0 = z, 1 = x, 2 = y
   logic signed [ANGLE_WIDTH-1:0] ang [3];
   logic signed [TH_W-1:0]        half_v [3];

   assign ang[0] = req_data.angle_z;
   assign ang[1] = req_data.angle_x;
   assign ang[2] = req_data.angle_y;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         half_v[a] = half_angle(ang[a]);
      end
   end

   // cordic rotators, stage 0 holds the folded half angle
   logic signed [TH_W-1:0]   cd_th_ff [CORDIC_STEPS+1][3];
   logic signed [TH_W-1:0]   cd_th_in [CORDIC_STEPS+1][3];
   logic signed [TRIG_W-1:0] cd_x_ff  [CORDIC_STEPS+1][3];
   logic signed [TRIG_W-1:0] cd_x_in  [CORDIC_STEPS+1][3];
   logic signed [TRIG_W-1:0] cd_y_ff  [CORDIC_STEPS+1][3];
   logic signed [TRIG_W-1:0] cd_y_in  [CORDIC_STEPS+1][3];
   logic                     cd_neg_ff [CORDIC_STEPS+1][3];
   logic                     cd_neg_in [CORDIC_STEPS+1][3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         // quadrant fold keeps the argument within +/- pi/2
         if (half_v[a] > HALF_PI_Q16) begin
            cd_th_in[0][a]  = half_v[a] - PI_Q16;
            cd_neg_in[0][a] = 1'b1;
         end else if (half_v[a] < -HALF_PI_Q16) begin
            cd_th_in[0][a]  = half_v[a] + PI_Q16;
            cd_neg_in[0][a] = 1'b1;
         end else begin
            cd_th_in[0][a]  = half_v[a];
            cd_neg_in[0][a] = 1'b0;
         end
         cd_x_in[0][a] = CORDIC_GAIN;
         cd_y_in[0][a] = '0;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         for (int a = 0; a < 3; a++) begin
            cd_neg_in[i+1][a] = cd_neg_ff[i][a];
            if (!cd_th_ff[i][a][TH_W-1]) begin
               cd_x_in[i+1][a]  = cd_x_ff[i][a] - (cd_y_ff[i][a] >>> i);
               cd_y_in[i+1][a]  = cd_y_ff[i][a] + (cd_x_ff[i][a] >>> i);
               cd_th_in[i+1][a] = cd_th_ff[i][a] - ATAN_TABLE[i];
            end else begin
               cd_x_in[i+1][a]  = cd_x_ff[i][a] + (cd_y_ff[i][a] >>> i);
               cd_y_in[i+1][a]  = cd_y_ff[i][a] - (cd_x_ff[i][a] >>> i);
               cd_th_in[i+1][a] = cd_th_ff[i][a] + ATAN_TABLE[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            for (int a = 0; a < 3; a++) begin
               cd_th_ff[i][a]  <= cd_th_in[i][a];
               cd_x_ff[i][a]   <= cd_x_in[i][a];
               cd_y_ff[i][a]   <= cd_y_in[i][a];
               cd_neg_ff[i][a] <= cd_neg_in[i][a];
            end
         end
      end
   end

   // unfold sign, then pair and triple products
   logic signed [TRIG_W-1:0] tr_s_ff [3];
   logic signed [TRIG_W-1:0] tr_c_ff [3];
   logic signed [PAIR_W-1:0] pr_ff [4];
   logic signed [TRIG_W-1:0] pr_cz_ff;
   logic signed [TRIG_W-1:0] pr_sz_ff;
   logic signed [TRI_W-1:0]  tp_ff [8];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 3; a++) begin
            tr_c_ff[a] <= cd_neg_ff[CORDIC_STEPS][a] ? -cd_x_ff[CORDIC_STEPS][a]
                                                     :  cd_x_ff[CORDIC_STEPS][a];
            tr_s_ff[a] <= cd_neg_ff[CORDIC_STEPS][a] ? -cd_y_ff[CORDIC_STEPS][a]
                                                     :  cd_y_ff[CORDIC_STEPS][a];
         end
         // cx*cy, sx*sy, sx*cy, cx*sy
         pr_ff[0] <= tr_c_ff[1] * tr_c_ff[2];
         pr_ff[1] <= tr_s_ff[1] * tr_s_ff[2];
         pr_ff[2] <= tr_s_ff[1] * tr_c_ff[2];
         pr_ff[3] <= tr_c_ff[1] * tr_s_ff[2];
         pr_cz_ff <= tr_c_ff[0];
         pr_sz_ff <= tr_s_ff[0];
         // term pairs for w, x, y, z
         tp_ff[0] <= pr_ff[0] * pr_cz_ff;
         tp_ff[1] <= pr_ff[1] * pr_sz_ff;
         tp_ff[2] <= pr_ff[1] * pr_cz_ff;
         tp_ff[3] <= pr_ff[0] * pr_sz_ff;
         tp_ff[4] <= pr_ff[2] * pr_cz_ff;
         tp_ff[5] <= pr_ff[3] * pr_sz_ff;
         tp_ff[6] <= pr_ff[3] * pr_cz_ff;
         tp_ff[7] <= pr_ff[2] * pr_sz_ff;
      end
   end

   // components in q24, squares and their sum
   logic signed [TRI_W:0]   tsum [4];
   logic signed [Q_W-1:0]   cq_ff [4];
   logic signed [SUM_W-1:0] sq_ff [4];
   logic signed [Q_W-1:0]   sq_q_ff [4];
   logic signed [SUM_W-1:0] ad_ff [2];
   logic signed [Q_W-1:0]   ad_q_ff [4];

   always_comb begin
      tsum[0] = (TRI_W+1)'(tp_ff[0]) - (TRI_W+1)'(tp_ff[1]);
      tsum[1] = (TRI_W+1)'(tp_ff[2]) + (TRI_W+1)'(tp_ff[3]);
      tsum[2] = (TRI_W+1)'(tp_ff[4]) + (TRI_W+1)'(tp_ff[5]);
      tsum[3] = (TRI_W+1)'(tp_ff[6]) - (TRI_W+1)'(tp_ff[7]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 4; k++) begin
            cq_ff[k]   <= tsum[k][PROD_SHIFT+Q_W-1:PROD_SHIFT];
            sq_ff[k]   <= cq_ff[k] * cq_ff[k];
            sq_q_ff[k] <= cq_ff[k];
            ad_q_ff[k] <= sq_q_ff[k];
         end
         ad_ff[0] <= sq_ff[0] + sq_ff[1];
         ad_ff[1] <= sq_ff[2] + sq_ff[3];
      end
   end

   // square root, one root bit per stage
   logic [SUM_W-1:0]      rt_rem_ff  [SQRT_STEPS+1];
   logic [SUM_W-1:0]      rt_rem_in  [SQRT_STEPS+1];
   logic [SUM_W-1:0]      rt_root_ff [SQRT_STEPS+1];
   logic [SUM_W-1:0]      rt_root_in [SQRT_STEPS+1];
   logic signed [Q_W-1:0] rt_q_ff    [SQRT_STEPS+1][4];
   logic [SUM_W-1:0]      sr_bit     [SQRT_STEPS];
   logic [SUM_W-1:0]      sr_trial   [SQRT_STEPS];

   always_comb begin
      rt_rem_in[0]  = $unsigned(ad_ff[0] + ad_ff[1]);
      rt_root_in[0] = '0;
      for (int j = 0; j < SQRT_STEPS; j++) begin
         sr_bit[j]   = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
         sr_trial[j] = rt_root_ff[j] + sr_bit[j];
         if (rt_rem_ff[j] >= sr_trial[j]) begin
            rt_rem_in[j+1]  = rt_rem_ff[j] - sr_trial[j];
            rt_root_in[j+1] = (rt_root_ff[j] >> 1) + sr_bit[j];
         end else begin
            rt_rem_in[j+1]  = rt_rem_ff[j];
            rt_root_in[j+1] = rt_root_ff[j] >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= SQRT_STEPS; j++) begin
            rt_rem_ff[j]  <= rt_rem_in[j];
            rt_root_ff[j] <= rt_root_in[j];
         end
         for (int k = 0; k < 4; k++) begin
            rt_q_ff[0][k] <= ad_q_ff[k];
            for (int j = 0; j < SQRT_STEPS; j++) begin
               rt_q_ff[j+1][k] <= rt_q_ff[j][k];
            end
         end
      end
   end

   // restoring division of |q| * 2^frac by the magnitude, one quotient bit per stage
   logic [Q_W-1:0]        mag;
   logic [Q_W-1:0]        dv_mag_ff [QT_W+1];
   logic                  dv_div_ff [QT_W+1];
   logic [R_W-1:0]        dv_r_ff   [QT_W+1][4];
   logic [R_W-1:0]        dv_r_in   [QT_W+1][4];
   logic [QT_W-1:0]       dv_qt_ff  [QT_W+1][4];
   logic [QT_W-1:0]       dv_qt_in  [QT_W+1][4];
   logic signed [Q_W-1:0] dv_q_ff   [QT_W+1][4];
   logic signed [R_W-1:0] q_ext     [4];
   logic [R_W-1:0]        dv_rr     [QT_W][4];
   logic                  dv_ge     [QT_W][4];

   assign mag = rt_root_ff[SQRT_STEPS][Q_W-1:0];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         q_ext[k]       = R_W'(rt_q_ff[SQRT_STEPS][k]);
         dv_r_in[0][k]  = $unsigned(q_ext[k][R_W-1] ? -q_ext[k] : q_ext[k]);
         dv_qt_in[0][k] = '0;
         for (int d = 0; d < QT_W; d++) begin
            dv_ge[d][k]      = dv_r_ff[d][k] >= R_W'(dv_mag_ff[d]);
            dv_rr[d][k]      = dv_ge[d][k] ? dv_r_ff[d][k] - R_W'(dv_mag_ff[d])
                                           : dv_r_ff[d][k];
            dv_r_in[d+1][k]  = dv_rr[d][k] << 1;
            dv_qt_in[d+1][k] = {dv_qt_ff[d][k][QT_W-2:0], dv_ge[d][k]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_mag_ff[0] <= mag;
         dv_div_ff[0] <= mag >= Q_W'(MAG_MIN_Q24);
         for (int d = 0; d < QT_W; d++) begin
            dv_mag_ff[d+1] <= dv_mag_ff[d];
            dv_div_ff[d+1] <= dv_div_ff[d];
         end
         for (int k = 0; k < 4; k++) begin
            dv_q_ff[0][k] <= rt_q_ff[SQRT_STEPS][k];
            for (int d = 0; d <= QT_W; d++) begin
               dv_r_ff[d][k]  <= dv_r_in[d][k];
               dv_qt_ff[d][k] <= dv_qt_in[d][k];
            end
            for (int d = 0; d < QT_W; d++) begin
               dv_q_ff[d+1][k] <= dv_q_ff[d][k];
            end
         end
      end
   end

   // sign, small-magnitude bypass and saturation
   logic signed [FIN_W-1:0]      fd_div [4];
   logic signed [FIN_W-1:0]      fd_raw [4];
   logic signed [FIN_W-1:0]      fd_sel [4];
   logic signed [QUAT_WIDTH-1:0] fd_out [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         fd_div[k] = $signed({{(FIN_W-QT_W){1'b0}}, dv_qt_ff[QT_W][k]});
         if (dv_q_ff[QT_W][k][Q_W-1]) begin
            fd_div[k] = -fd_div[k];
         end
         fd_raw[k] = (FIN_W'(dv_q_ff[QT_W][k]) >>> SH_DN) <<< SH_UP;
         fd_sel[k] = dv_div_ff[QT_W] ? fd_div[k] : fd_raw[k];
         if (fd_sel[k] > ONE_F) begin
            fd_sel[k] = ONE_F;
         end else if (fd_sel[k] < NEG_ONE_F) begin
            fd_sel[k] = NEG_ONE_F;
         end
         fd_out[k] = QUAT_WIDTH'(fd_sel[k]);
      end
      fin_data.quat_w = fd_out[0];
      fin_data.quat_x = fd_out[1];
      fin_data.quat_y = fd_out[2];
      fin_data.quat_z = fd_out[3];
   end

   // output register with one skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (vld_ff[V_LAST]) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) begin
            rsp_data_ff <= skid_ff;
         end
      end else if (vld_ff[V_LAST]) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_ff <= fin_data;
         end else begin
            skid_ff <= fin_data;
         end
      end
   end

   // checks
   `ETQ_ASSERT_IMPLY(a_skid_needs_out, skid_full_ff, rsp_valid_ff, "skid word without output word")
   `ETQ_ASSERT_NEXT(a_skid_drains, skid_full_ff && !rsp_stall, !skid_full_ff && rsp_valid_ff, "skid word not moved to output")
   `ETQ_ASSERT_IMPLY(a_root_floor, vld_ff[V_SQRT_END], rt_rem_ff[SQRT_STEPS] <= (rt_root_ff[SQRT_STEPS] << 1), "square root not floored")
   `ETQ_ASSERT_IMPLY(a_quot_bound, vld_ff[V_LAST] && dv_div_ff[QT_W], fd_div[0] <= ONE_F && fd_div[0] >= NEG_ONE_F, "normalized w beyond one")

endmodule

// File: bench/tb_euler_to_quaternion_unit.sv
`timescale 1ns / 1ps
module tb_euler_to_quaternion_unit;
   import etq_pkg::*;

   localparam int PIPE_DEPTH = 70;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_WORDS = 1300;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   etq_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   etq_rsp_type rsp_data;

   euler_to_quaternion_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   etq_rsp_type quat_pending[$];
   int          err_count;
   int          idle_cycles;
   bit          calm_phase;
   bit          hold_rsp;

   // sin and cos of half an angle, q16, cordic with quadrant fold
   function automatic void half_trig(input logic signed [ANGLE_WIDTH-1:0] a,
                                     output longint s, output longint c);
      longint th, x, y, dx, dy;
      bit flip;
      longint atan_q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                256, 128, 64, 32, 16, 8, 4, 2};
      th = longint'(a) * 4;
      x = 39797;
      y = 0;
      flip = 0;
      if (th > 102944) begin
         th -= 205887;
         flip = 1;
      end else if (th < -102944) begin
         th += 205887;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (th >= 0) begin
            x -= dx;
            y += dy;
            th -= atan_q16[i];
         end else begin
            x += dx;
            y -= dy;
            th += atan_q16[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint root_floor(input longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   function automatic etq_rsp_type quat_from_euler(input etq_req_type e);
      longint sz, cz, sx, cx, sy, cy, mag, v;
      longint q[4];
      longint unsigned sum;
      logic signed [QUAT_WIDTH-1:0] o[4];
      etq_rsp_type r;
      half_trig(e.angle_z, sz, cz);
      half_trig(e.angle_x, sx, cx);
      half_trig(e.angle_y, sy, cy);
      q[0] = cx*cy*cz - sx*sy*sz;
      q[1] = sx*sy*cz + cx*cy*sz;
      q[2] = sx*cy*cz + cx*sy*sz;
      q[3] = cx*sy*cz - sx*cy*sz;
      sum = 0;
      for (int k = 0; k < 4; k++) begin
         q[k] = q[k] >>> 24;
         sum += longint'(q[k] * q[k]);
      end
      mag = root_floor(sum);
      for (int k = 0; k < 4; k++) begin
         // normalize unless the magnitude is too small to divide by
         if (mag >= MAG_MIN_Q24) v = (q[k] * 16384) / mag;
         else v = q[k] >>> 10;
         if (v > 16384) v = 16384;
         if (v < -16384) v = -16384;
         o[k] = v[QUAT_WIDTH-1:0];
      end
      r.quat_w = o[0];
      r.quat_x = o[1];
      r.quat_y = o[2];
      r.quat_z = o[3];
      return r;
   endfunction

   // directed words with hand-known results where obvious
   typedef struct {
      etq_req_type angles;
      bit          known;
      etq_rsp_type quat;
   } dir_row_type;

   dir_row_type dir_rows[$];

   function automatic etq_req_type mk_angles(input int z, input int x, input int y);
      etq_req_type a;
      a.angle_z = z[15:0];
      a.angle_x = x[15:0];
      a.angle_y = y[15:0];
      return a;
   endfunction

   task automatic add_row(input int z, input int x, input int y, input bit known,
                          input int w = 0, input int qx = 0, input int qy = 0,
                          input int qz = 0);
      dir_row_type r;
      r.angles = mk_angles(z, x, y);
      r.known = known;
      r.quat.quat_w = w[15:0];
      r.quat.quat_x = qx[15:0];
      r.quat.quat_y = qy[15:0];
      r.quat.quat_z = qz[15:0];
      dir_rows.push_back(r);
   endtask

   // sender: push one word and wait for it to be taken
   task automatic send_word(input etq_req_type a);
      req_data <= a;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      quat_pending.push_back(quat_from_euler(a));
   endtask

   task automatic send_gap();
      int n;
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic etq_req_type rand_angles();
      etq_req_type a;
      int pick;
      a = etq_req_type'(48'({$urandom, $urandom}));
      pick = $urandom_range(0, 9);
      // near-extreme and near-quadrant-fold values now and then
      if (pick == 0) a.angle_z = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (pick == 1) a.angle_x = 16'(25736 + int'($urandom_range(0, 8)) - 4);
      if (pick == 2) a.angle_y = 16'(-25736 + int'($urandom_range(0, 8)) - 4);
      if (pick == 3) a = mk_angles($urandom_range(0, 15) - 8, $urandom_range(0, 15) - 8,
                                   $urandom_range(0, 15) - 8);
      return a;
   endfunction

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      calm_phase = 0;
      add_row(0, 0, 0, 1, 16384, 0, 0, 0);
      add_row(32767, 32767, 32767, 0);
      add_row(-32768, -32768, -32768, 0);
      add_row(-32768, 0, 0, 0);
      add_row(0, -32768, 0, 0);
      add_row(0, 0, -32768, 0);
      add_row(32767, 0, 0, 0);
      add_row(0, 32767, 0, 0);
      add_row(0, 0, 32767, 0);
      add_row(25736, 0, 0, 0);
      add_row(25737, 0, 0, 0);
      add_row(-25736, 0, 0, 0);
      add_row(-25737, 0, 0, 0);
      add_row(0, 25735, -25738, 0);
      add_row(12868, 12868, 12868, 0);
      add_row(-1, 1, -1, 0);
      add_row(16'h5555, 16'h2aaa, -21846, 0);
      add_row(-12868, 25736, 6434, 0);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[i]) begin
         send_word(dir_rows[i].angles);
         if (dir_rows[i].known) quat_pending[$] = dir_rows[i].quat;
         send_gap();
      end
      // random words; midway, drain fully before going on
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS / 2) begin
            req_valid <= 1'b0;
            while (quat_pending.size() != 0) @(posedge clock);
         end
         if (i > RANDOM_WORDS - 150) calm_phase = 1;
         send_word(rand_angles());
         send_gap();
      end
      req_valid <= 1'b0;
      while (quat_pending.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 10) @(posedge clock);
      if (err_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   // long receiver hold-off, timed here by clock edges from the start of the run
   initial begin
      hold_rsp = 0;
      repeat (600) @(posedge clock);
      hold_rsp = 1;
      repeat (300) @(posedge clock);
      hold_rsp = 0;
   end

   // receiver stall bursts
   initial begin
      int n;
      rsp_stall = 1'b1;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) begin
               if (!hold_rsp) @(posedge clock);
            end
         end
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      etq_rsp_type e;
      if (reset) begin
         err_count <= 0;
         idle_cycles <= 0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (quat_pending.size() == 0) begin
               $display("%0t: unexpected word %h", $realtime, rsp_data);
               err_count <= err_count + 1;
            end else begin
               e = quat_pending.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: mismatch w/x/y/z expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                           $realtime, e.quat_w, e.quat_x, e.quat_y, e.quat_z,
                           rsp_data.quat_w, rsp_data.quat_x, rsp_data.quat_y,
                           rsp_data.quat_z);
                  err_count <= err_count + 1;
               end
            end
         end
      end
   end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/etq_pkg.sv
hw/rtl/euler_to_quaternion_unit.sv
bench/tb_euler_to_quaternion_unit.sv
